// File: rtl/usvs_pkg.sv
// ----------------------------------------------------------------------------
// usvs_pkg
// Shared types and constants for the UV seam vertex splitter.
// ----------------------------------------------------------------------------
package usvs_pkg;

    localparam int INDEX_W  = 16;
    localparam int COORD_W  = 32;
    localparam int COUNT_W  = 17;
    localparam int STATUS_W = 2;
    localparam int EPOCH_W  = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FLAT_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 2'd1;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_INDEX = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

    // one store entry: mesh epoch tag plus the recorded coordinates
    typedef struct packed {
        logic [EPOCH_W-1:0] epoch;
        logic [COORD_W-1:0] v;
        logic [COORD_W-1:0] u;
    } usvs_entry_t;

    typedef enum logic {
        ST_SWEEP,
        ST_RUN
    } usvs_state_t;

endpackage

// File: rtl/usvs_if.sv
// ----------------------------------------------------------------------------
// usvs interfaces
// Valid/ready channels for corners, results and register writes.
// ----------------------------------------------------------------------------
interface usvs_corner_if;
    logic        valid;
    logic        ready;
    logic        new_mesh;
    logic [15:0] corner_index;
    logic [31:0] coord_u;
    logic [31:0] coord_v;

    modport source (output valid, new_mesh, corner_index, coord_u, coord_v, input ready);
    modport sink   (input valid, new_mesh, corner_index, coord_u, coord_v, output ready);
endinterface

interface usvs_result_if;
    logic        valid;
    logic        ready;
    logic [15:0] mapped_index;
    logic        duplicated;
    logic [15:0] copy_source;
    logic [31:0] out_u;
    logic [31:0] out_v;
    logic [1:0]  status;

    modport source (output valid, mapped_index, duplicated, copy_source, out_u, out_v,
                    status, input ready);
    modport sink   (input valid, mapped_index, duplicated, copy_source, out_u, out_v,
                    status, output ready);
endinterface

interface usvs_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [16:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/uv_seam_vertex_splitter.sv
// ----------------------------------------------------------------------------
// uv_seam_vertex_splitter
// Remaps triangle corners so vertices split along texture coordinate seams.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+------------------------------------------
//  corner   | in  | valid / ready | new_mesh, corner_index, coord_u, coord_v
//  result   | out | valid / ready | mapped_index, duplicated, copy_source,
//           |     |               | out_u, out_v, status
//  cfg      | in  | valid / ready | index, data (always ready)
//
// One corner per cycle while results are taken: the store read issues at
// accept, the compare and write-back run in the compare stage, with the
// last write forwarded. After reset a clearing pass writes every store
// entry (DEPTH = min(MAX_VERTICES, 65536)) before the first corner is taken.
// Meshes are tagged by an 8-bit epoch; the 255th new_mesh, and every 254th
// after it, waits for a repeat of the pass.
// A stalled result holds one corner in the compare stage; corner.ready drops.
// ----------------------------------------------------------------------------
module uv_seam_vertex_splitter #(
    parameter int MAX_VERTICES = 65536
) (
    input  logic       clk,
    input  logic       rst_n,
    usvs_cfg_if.sink   cfg,
    usvs_corner_if.sink corner,
    usvs_result_if.source result
);
    import usvs_pkg::*;

    localparam int DEPTH = (MAX_VERTICES > 65536) ? 65536 : MAX_VERTICES;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [17:0]   CAP      = 18'(DEPTH);
    localparam logic [AW-1:0] LAST_ROW = AW'(DEPTH - 1);

    // configuration
    logic               flat_mode_reg;
    logic [COUNT_W-1:0] vertex_count_reg;

    // control
    usvs_state_t        state_reg, state_next;
    logic [AW-1:0]      sweep_cnt_reg;
    logic [EPOCH_W-1:0] epoch_reg;
    logic [COUNT_W-1:0] appended_reg;

    // compare stage
    logic               s1_valid_reg;
    logic               s1_new_mesh_reg;
    logic [INDEX_W-1:0] s1_idx_reg;
    logic [COORD_W-1:0] s1_u_reg;
    logic [COORD_W-1:0] s1_v_reg;

    // last write, forwarded to the next read
    logic               fwd_valid_reg;
    logic               fwd_tag_reg;
    logic [AW-1:0]      fwd_addr_reg;
    usvs_entry_t        fwd_data_reg;

    // result register
    logic                out_valid_reg;
    logic [INDEX_W-1:0]  mapped_reg;
    logic                dup_reg;
    logic [INDEX_W-1:0]  source_reg;
    logic [COORD_W-1:0]  out_u_reg;
    logic [COORD_W-1:0]  out_v_reg;
    logic [STATUS_W-1:0] status_reg;

    // memory ports
    logic        wr_en;
    logic        wr_tag_en;
    logic [AW-1:0] wr_addr;
    usvs_entry_t wr_data;
    usvs_entry_t rd_data;

    logic               epoch_wrap;
    logic               s1_fire;
    logic               in_fire;
    logic               fwd_hit;
    usvs_entry_t        entry;
    logic               visited;
    logic               bad_index;
    logic               need_new;
    logic [COUNT_W-1:0] app_eff;
    logic [17:0]        fresh;
    logic               full;
    logic               run_write;
    logic               append_write;
    logic               store_write;
    logic               sweep_done;

    // ---------------------------------------------------------------- config
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flat_mode_reg    <= 1'b0;
            vertex_count_reg <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_FLAT_MODE:    flat_mode_reg    <= cfg.data[0];
                CFG_VERTEX_COUNT: vertex_count_reg <= cfg.data[COUNT_W-1:0];
                default:          ;
            endcase
        end
    end

    // ---------------------------------------------------------------- control
    assign epoch_wrap = corner.new_mesh && (epoch_reg == '1);
    assign s1_fire    = s1_valid_reg && (!out_valid_reg || result.ready);
    assign corner.ready = (state_reg == ST_RUN) && !epoch_wrap
                          && (!s1_valid_reg || s1_fire);
    assign in_fire    = corner.valid && corner.ready;
    assign sweep_done = (sweep_cnt_reg == LAST_ROW);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_SWEEP:
            begin
                if (sweep_done)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                // tags would alias: clear the store once the stage has drained
                if (corner.valid && epoch_wrap && !s1_valid_reg)
                begin
                    state_next = ST_SWEEP;
                end
            end
            default: state_next = ST_SWEEP;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_SWEEP;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_cnt_reg <= '0;
            epoch_reg     <= '0;
        end
        else if (state_reg == ST_SWEEP)
        begin
            sweep_cnt_reg <= sweep_done ? '0 : sweep_cnt_reg + 1'b1;
            if (sweep_done)
            begin
                epoch_reg <= EPOCH_W'(1);
            end
        end
        else if (in_fire && corner.new_mesh)
        begin
            epoch_reg <= epoch_reg + 1'b1;
        end
    end

    // ---------------------------------------------------------------- compare
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_new_mesh_reg <= corner.new_mesh;
            s1_idx_reg      <= corner.corner_index;
            s1_u_reg        <= corner.coord_u;
            s1_v_reg        <= corner.coord_v;
        end
    end

    assign fwd_hit = fwd_valid_reg && (fwd_addr_reg == s1_idx_reg[AW-1:0]);

    // an appended-slot write leaves the tag alone, so only coords come forward
    always_comb
    begin
        entry = rd_data;
        if (fwd_hit)
        begin
            entry.u = fwd_data_reg.u;
            entry.v = fwd_data_reg.v;
            if (fwd_tag_reg)
            begin
                entry.epoch = fwd_data_reg.epoch;
            end
        end
    end

    assign visited   = (entry.epoch == epoch_reg);
    assign bad_index = ({1'b0, s1_idx_reg} >= vertex_count_reg)
                       || ({2'b00, s1_idx_reg} >= CAP);
    assign need_new  = visited && (flat_mode_reg
                       || (entry.u != s1_u_reg) || (entry.v != s1_v_reg));
    assign app_eff   = s1_new_mesh_reg ? '0 : appended_reg;
    assign fresh     = {1'b0, vertex_count_reg} + {1'b0, app_eff};
    assign full      = need_new && (fresh >= CAP);
    assign run_write = s1_fire && !bad_index && !visited;
    assign append_write = s1_fire && !bad_index && need_new && !full;
    assign store_write  = run_write || append_write;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            appended_reg <= '0;
        end
        else if (s1_fire)
        begin
            if (!bad_index && need_new && !full)
            begin
                appended_reg <= app_eff + 1'b1;
            end
            else
            begin
                appended_reg <= app_eff;
            end
        end
    end

    // ---------------------------------------------------------------- store
    always_comb
    begin
        if (state_reg == ST_SWEEP)
        begin
            wr_en     = 1'b1;
            wr_tag_en = 1'b1;
            wr_addr   = sweep_cnt_reg;
            wr_data   = '0;
        end
        else
        begin
            // first visit tags and records; a new vertex only records coords
            wr_en     = store_write;
            wr_tag_en = run_write;
            wr_addr   = run_write ? s1_idx_reg[AW-1:0] : fresh[AW-1:0];
            wr_data   = '{epoch: epoch_reg, v: s1_v_reg, u: s1_u_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_valid_reg <= 1'b0;
        end
        else if (state_reg == ST_SWEEP)
        begin
            fwd_valid_reg <= 1'b0;
        end
        else if (store_write)
        begin
            fwd_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_write)
        begin
            fwd_tag_reg  <= run_write;
            fwd_addr_reg <= wr_addr;
            fwd_data_reg <= wr_data;
        end
    end

    usvs_store_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_tag_en (wr_tag_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (in_fire),
        .rd_addr   (corner.corner_index[AW-1:0]),
        .rd_data   (rd_data)
    );

    // ---------------------------------------------------------------- result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            if (bad_index || full)
            begin
                mapped_reg <= '0;
                dup_reg    <= 1'b0;
                source_reg <= '0;
                out_u_reg  <= '0;
                out_v_reg  <= '0;
                status_reg <= bad_index ? STATUS_BAD_INDEX : STATUS_FULL;
            end
            else
            begin
                mapped_reg <= need_new ? fresh[INDEX_W-1:0] : s1_idx_reg;
                dup_reg    <= need_new;
                source_reg <= s1_idx_reg;
                out_u_reg  <= s1_u_reg;
                out_v_reg  <= s1_v_reg;
                status_reg <= STATUS_OK;
            end
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.mapped_index = mapped_reg;
    assign result.duplicated   = dup_reg;
    assign result.copy_source  = source_reg;
    assign result.out_u        = out_u_reg;
    assign result.out_v        = out_v_reg;
    assign result.status       = status_reg;

endmodule

// File: rtl/usvs_store_ram.sv
// ----------------------------------------------------------------------------
// usvs_store_ram
// Vertex store: epoch tag array and coordinate array on one write port and
// one read port, registered read data. The tag is written only on request.
// ----------------------------------------------------------------------------
module usvs_store_ram #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic                  wr_tag_en,
    input  logic [AW-1:0]         wr_addr,
    input  usvs_pkg::usvs_entry_t wr_data,
    input  logic                  rd_en,
    input  logic [AW-1:0]         rd_addr,
    output usvs_pkg::usvs_entry_t rd_data
);
    import usvs_pkg::*;

    logic [EPOCH_W-1:0]   tag_mem_reg   [DEPTH];
    logic [2*COORD_W-1:0] coord_mem_reg [DEPTH];
    logic [EPOCH_W-1:0]   rd_tag_reg;
    logic [2*COORD_W-1:0] rd_coord_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            coord_mem_reg[wr_addr] <= {wr_data.v, wr_data.u};
            if (wr_tag_en)
            begin
                tag_mem_reg[wr_addr] <= wr_data.epoch;
            end
        end
    end

    // read returns the old contents on a same-address write
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_tag_reg   <= tag_mem_reg[rd_addr];
            rd_coord_reg <= coord_mem_reg[rd_addr];
        end
    end

    assign rd_data = {rd_tag_reg, rd_coord_reg};

endmodule
